// ----- design/clpws_pkg.sv -----
// ----------------------------------------------------------------------------
// clpws_pkg: shared types and constants for the character LCD write sequencer
// Holds the phase and request-kind codes, the item and result records, the
// configuration defaults and the init command table.
// ----------------------------------------------------------------------------
package clpws_pkg;

    localparam int LINE_CHARS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SETUP_W = 16;
    localparam int WAIT_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER = 2'd3;

    localparam logic [SETUP_W-1:0] SETUP_RST = 16'd50;
    localparam logic [WAIT_W-1:0]  SHORT_RST = 24'd50000;
    localparam logic [WAIT_W-1:0]  LONG_RST  = 24'd100000;
    localparam logic [WAIT_W-1:0]  POWER_RST = 24'd750000;

    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [6:0] CMD_HOME_TOP    = 7'h01;
    localparam logic [7:0] CMD_SECOND_LINE = 8'hC0;
    localparam logic [2:0] INIT_COUNT      = 3'd4;
    localparam logic [2:0] INIT_LAST       = 3'd3;

    typedef enum logic [6:0] {
        PH_POWER = 7'b0000001,
        PH_RS    = 7'b0000010,
        PH_DATA  = 7'b0000100,
        PH_EHIGH = 7'b0001000,
        PH_ELOW  = 7'b0010000,
        PH_WAIT  = 7'b0100000,
        PH_IDLE  = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CMD,
        KIND_CHAR,
        KIND_CHAR_START
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_item;

    typedef struct packed {
        logic [SETUP_W-1:0] setup_ticks;
        logic [WAIT_W-1:0]  short_wait_ticks;
        logic [WAIT_W-1:0]  long_wait_ticks;
        logic [WAIT_W-1:0]  power_up_ticks;
    } t_cfg;

    typedef struct packed {
        logic       lcd_rs;
        logic       lcd_en;
        logic [7:0] lcd_data;
        logic       ready_res;
        logic       accepted;
    } t_res;

    function automatic logic [7:0] init_code(input logic [1:0] step);
        logic [7:0] code;
        case (step)
            2'd0:    code = 8'h38;
            2'd1:    code = 8'h01;
            2'd2:    code = 8'h06;
            default: code = 8'h0F;
        endcase
        return code;
    endfunction

endpackage

// ----- design/clpws_if.sv -----
// ----------------------------------------------------------------------------
// clpws_if: request and result channels of the character LCD write sequencer
// Each channel carries valid, ready and one item of payload.
// ----------------------------------------------------------------------------
interface lcd_req_if;
    logic       valid;
    logic       ready;
    logic       req_valid;
    logic       req_is_char;
    logic [7:0] req_byte;
    logic       req_string_start;

    modport source (output valid, req_valid, req_is_char, req_byte, req_string_start,
                    input ready);
    modport sink   (input valid, req_valid, req_is_char, req_byte, req_string_start,
                    output ready);
endinterface

interface lcd_res_if;
    logic       valid;
    logic       ready;
    logic       lcd_rs;
    logic       lcd_en;
    logic [7:0] lcd_data;
    logic       ready_res;
    logic       accepted;

    modport source (output valid, lcd_rs, lcd_en, lcd_data, ready_res, accepted,
                    input ready);
    modport sink   (input valid, lcd_rs, lcd_en, lcd_data, ready_res, accepted,
                    output ready);
endinterface

// ----- design/char_lcd_parallel_write_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// char_lcd_parallel_write_sequencer_top: 8-bit parallel character LCD writer
// Drives RS, E and D0..D7 of an HD44780-style display, one request per tick.
// ----------------------------------------------------------------------------
// Each request on i_req is one timing tick. It may carry a command or a
// character; the matching result on o_res gives the pin levels after that
// tick together with ready_res and accepted. Requests that arrive while a
// write, the power-up delay or the init sequence is running are dropped and
// reported with accepted low. Exactly one result leaves for each request.
// A request passes an intake register, a four-entry queue and the sequencer
// with its result register. With the queue empty, a request moves from the intake
// register to the queue entry and on to the result register. One request per cycle
// is sustained while the receiver takes results. The queue lets intake keep taking
// requests during receiver stalls; i_req.ready falls once it and the intake are full.
// Reset starts the power-up delay and loads the timing registers with their defaults.
// Timing registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write them only while no request is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module char_lcd_parallel_write_sequencer_top
    import clpws_pkg::*;
#(
    parameter int LINE_CHARS  = LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcd_req_if.sink               i_req,
    lcd_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_item front_item;
    t_item queue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_ticks      <= SETUP_RST;
            r_cfg.short_wait_ticks <= SHORT_RST;
            r_cfg.long_wait_ticks  <= LONG_RST;
            r_cfg.power_up_ticks   <= POWER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETUP: r_cfg.setup_ticks      <= i_cfg_data[SETUP_W-1:0];
                CFG_SHORT: r_cfg.short_wait_ticks <= i_cfg_data[WAIT_W-1:0];
                CFG_LONG:  r_cfg.long_wait_ticks  <= i_cfg_data[WAIT_W-1:0];
                CFG_POWER: r_cfg.power_up_ticks   <= i_cfg_data[WAIT_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    clpws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_push  (push),
        .o_item  (front_item),
        .i_full  (full)
    );

    clpws_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    clpws_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (queue_item),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ----- design/clpws_front.sv -----
// ----------------------------------------------------------------------------
// clpws_front: request intake and classification
// Takes one tick request per cycle while the queue has room, sorts it into
// none, command, character or string start, and hands it on to the queue.
// ----------------------------------------------------------------------------
module clpws_front
    import clpws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcd_req_if.sink     i_req,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_req.ready = !r_valid || !i_full;
    assign o_push      = r_valid && !i_full;
    assign o_item      = r_item;

    always_comb begin
        n_item.code = i_req.req_byte;
        if (!i_req.req_valid) begin
            n_item.kind = KIND_NONE;
        end else if (!i_req.req_is_char) begin
            n_item.kind = KIND_CMD;
        end else if (i_req.req_string_start) begin
            n_item.kind = KIND_CHAR_START;
        end else begin
            n_item.kind = KIND_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- design/clpws_fifo.sv -----
// ----------------------------------------------------------------------------
// clpws_fifo: short request queue
// Decouples request intake from the bus sequencer so each side can stall.
// ----------------------------------------------------------------------------
module clpws_fifo
    import clpws_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- design/clpws_back.sv -----
// ----------------------------------------------------------------------------
// clpws_back: LCD bus sequencer
// Advances the power-up, init and byte-write timing by one tick for each
// queued request and registers the pin levels as a result.
// ----------------------------------------------------------------------------
module clpws_back
    import clpws_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_item     i_item,
    input  logic      i_empty,
    output logic      o_pop,
    lcd_res_if.source o_res
);

    localparam int COL_W = $clog2(LINE_CHARS + 2);
    localparam logic [COL_W-1:0] COL_FULL = COL_W'(LINE_CHARS);
    localparam logic [COL_W-1:0] COL_SAT  = COL_W'(LINE_CHARS + 1);

    t_phase            r_phase, n_phase;
    logic [WAIT_W-1:0] r_cnt, n_cnt;
    logic [2:0]        r_init, n_init;
    logic [7:0]        r_held, n_held;
    logic              r_held_char, n_held_char;
    logic [8:0]        r_defer, n_defer;
    logic [COL_W-1:0]  r_col, n_col;
    logic [7:0]        r_pin, n_pin;
    logic              r_out_valid;
    t_res              r_res;
    t_res              n_res;

    logic [WAIT_W-1:0] len;
    logic [WAIT_W:0]   cnt_inc;
    logic              cnt_more;
    logic              idle;
    logic              acc;
    logic              long_cmd;
    logic [COL_W-1:0]  col_start;
    logic [2:0]        init_next;

    assign o_pop = !i_empty && (!r_out_valid || o_res.ready);

    assign o_res.valid     = r_out_valid;
    assign o_res.lcd_rs    = r_res.lcd_rs;
    assign o_res.lcd_en    = r_res.lcd_en;
    assign o_res.lcd_data  = r_res.lcd_data;
    assign o_res.ready_res = r_res.ready_res;
    assign o_res.accepted  = r_res.accepted;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_init      = r_init;
        n_held      = r_held;
        n_held_char = r_held_char;
        n_defer     = r_defer;
        n_col       = r_col;
        n_pin       = r_pin;

        // Clear and cursor home need the long wait.
        long_cmd = (r_held == CMD_CLEAR) || (r_held[7:1] == CMD_HOME_TOP);
        case (r_phase)
            PH_POWER: len = i_cfg.power_up_ticks;
            PH_WAIT:  len = long_cmd ? i_cfg.long_wait_ticks : i_cfg.short_wait_ticks;
            default:  len = WAIT_W'(i_cfg.setup_ticks);
        endcase
        // A length of zero behaves as one tick, since the count plus one is never below one.
        cnt_inc   = {1'b0, r_cnt} + 1'b1;
        cnt_more  = cnt_inc < {1'b0, len};
        idle      = (r_phase == PH_IDLE);
        acc       = idle && (i_item.kind != KIND_NONE);
        col_start = (i_item.kind == KIND_CHAR_START) ? '0 : r_col;
        init_next = r_init + 1'b1;

        if (o_pop) begin
            if (acc) begin
                n_phase = PH_RS;
                n_cnt   = '0;
                if (i_item.kind == KIND_CMD) begin
                    n_held      = i_item.code;
                    n_held_char = 1'b0;
                end else begin
                    if (col_start == COL_FULL) begin
                        // The first character past the line goes after a line break.
                        n_defer     = {1'b1, i_item.code};
                        n_held      = CMD_SECOND_LINE;
                        n_held_char = 1'b0;
                    end else begin
                        n_held      = i_item.code;
                        n_held_char = 1'b1;
                    end
                    n_col = (col_start < COL_SAT) ? col_start + 1'b1 : col_start;
                end
            end else if (!idle) begin
                if (cnt_more) begin
                    n_cnt = cnt_inc[WAIT_W-1:0];
                end else begin
                    n_cnt = '0;
                    case (r_phase)
                        PH_POWER: begin
                            n_init      = '0;
                            n_held      = init_code(2'd0);
                            n_held_char = 1'b0;
                            n_phase     = PH_RS;
                        end
                        PH_RS: begin
                            n_phase = PH_DATA;
                            n_pin   = r_held;
                        end
                        PH_DATA:  n_phase = PH_EHIGH;
                        PH_EHIGH: n_phase = PH_ELOW;
                        PH_ELOW:  n_phase = r_held_char ? PH_IDLE : PH_WAIT;
                        PH_WAIT: begin
                            n_phase = PH_IDLE;
                            if (r_init < INIT_COUNT) begin
                                n_init = init_next;
                                if (r_init < INIT_LAST) begin
                                    n_held      = init_code(init_next[1:0]);
                                    n_held_char = 1'b0;
                                    n_phase     = PH_RS;
                                end
                            end else if (r_defer[8]) begin
                                n_held      = r_defer[7:0];
                                n_held_char = 1'b1;
                                n_defer     = '0;
                                n_phase     = PH_RS;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
        end

        n_res.lcd_rs    = (n_phase == PH_POWER) ? 1'b0 : n_held_char;
        n_res.lcd_en    = (n_phase == PH_EHIGH);
        n_res.lcd_data  = n_pin;
        n_res.ready_res = idle;
        n_res.accepted  = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_POWER;
            r_cnt       <= '0;
            r_init      <= '0;
            r_held      <= '0;
            r_held_char <= 1'b0;
            r_defer     <= '0;
            r_col       <= '0;
            r_pin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_init      <= n_init;
            r_held      <= n_held;
            r_held_char <= n_held_char;
            r_defer     <= n_defer;
            r_col       <= n_col;
            r_pin       <= n_pin;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    a_acc_needs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && acc) |=> (r_phase == PH_RS && r_cnt == '0))
        else $error("accepted request did not start a byte write");

    a_defer_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_defer[8] |-> (r_init == INIT_COUNT))
        else $error("deferred character held before init finished");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0))
        else $error("phase counter not cleared in idle");

    a_column_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_SAT)
        else $error("string column beyond saturation");

    a_result_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.accepted) |-> r_res.ready_res)
        else $error("result marks a request taken while busy");

endmodule
